// ----- hdl/top_k_play_count_tracker_defines.svh -----
// Assertion macros for the top-K play count tracker.
// Used by the files that carry concurrent assertions; depends on nothing.
`ifndef TOP_K_PLAY_COUNT_TRACKER_DEFINES_SVH
`define TOP_K_PLAY_COUNT_TRACKER_DEFINES_SVH

// Implication in the same cycle, disabled while reset is low.
`define TKPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, disabled while reset is low.
`define TKPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tkpc_pkg.sv -----
// Shared types and constants of the top-K play count tracker.
// Used by the totals memory, the ranked list and the top level; depends on nothing.
`timescale 1ns / 1ps

package tkpc_pkg;

    localparam int ID_W   = 10;
    localparam int TOT_W  = 30;
    localparam int TOP_W  = 5;
    localparam int DATA_W = 40;

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_QUERY    = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_INSERT,
        ST_QUERY
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [TOT_W-1:0] total;
    } t_entry;

    typedef struct packed {
        logic   load;
        logic   step;
        logic   insert;
        t_entry entry;
    } t_rank_cmd;

    typedef struct packed {
        t_entry head;
        logic   next_valid;
    } t_rank_stat;

endpackage

// ----- hdl/tkpc_totals_ram.sv -----
// Play totals memory: one write port and one registered read port.
// Depends on tkpc_pkg for the total width.
`timescale 1ns / 1ps

module tkpc_totals_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [tkpc_pkg::TOT_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [tkpc_pkg::TOT_W-1:0] o_rdata
);

    logic [tkpc_pkg::TOT_W-1:0] r_mem [DEPTH];
    logic [tkpc_pkg::TOT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tkpc_rank_list.sv -----
// Ranked list of the best entries, kept as a circular row of cells.
// One shared rank comparator merges a carried entry into the list as it rotates.
// Depends on tkpc_pkg for the entry and command types.
`timescale 1ns / 1ps

module tkpc_rank_list #(
    parameter int K_MAX = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tkpc_pkg::t_rank_cmd  i_cmd,
    output tkpc_pkg::t_rank_stat o_stat
);

    tkpc_pkg::t_entry r_cells [K_MAX];
    tkpc_pkg::t_entry r_carry;
    logic [tkpc_pkg::ID_W-1:0] r_key_id;

    tkpc_pkg::t_entry w_head;
    tkpc_pkg::t_entry w_win;
    tkpc_pkg::t_entry w_lose;
    logic             w_above;
    logic             w_drop;
    logic             w_next_valid;

    // The old entry of the id being updated leaves the list as an empty slot,
    // so the carried entry takes its place in the merge.
    always_comb begin
        w_drop  = (r_cells[0].total != '0) && (r_cells[0].id == r_key_id);
        w_head  = w_drop ? '0 : r_cells[0];
        w_above = (r_carry.total > w_head.total) ||
                  ((r_carry.total == w_head.total) && (r_carry.id > w_head.id));
        w_win   = w_above ? r_carry : w_head;
        w_lose  = w_above ? w_head : r_carry;
    end

    generate
        if (K_MAX > 1) begin : g_next
            assign w_next_valid = (r_cells[1].total != '0);
        end else begin : g_single
            assign w_next_valid = 1'b0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < K_MAX; i++) begin
                r_cells[i] <= '0;
            end
            r_carry  <= '0;
            r_key_id <= '0;
        end else if (i_cmd.load) begin
            r_carry  <= i_cmd.entry;
            r_key_id <= i_cmd.entry.id;
        end else if (i_cmd.step) begin
            for (int i = 0; i < K_MAX - 1; i++) begin
                r_cells[i] <= r_cells[i+1];
            end
            r_cells[K_MAX-1] <= i_cmd.insert ? w_win : r_cells[0];
            if (i_cmd.insert) begin
                r_carry <= w_lose;
            end
        end
    end

    assign o_stat.head       = r_cells[0];
    assign o_stat.next_valid = w_next_valid;

endmodule

// ----- hdl/top_k_play_count_tracker.sv -----
// Top-K play count tracker. A register transaction runs through accept,
// totals read, add and write, then K_MAX merge steps of the ranked list.
// A query takes K_MAX rotation steps; up to the clamped top count, results leave
// one per cycle from the first step on, and a stalled output register holds the
// rotation. After reset a clearing pass zeroes the totals memory; no stream
// input is taken until it ends. Ignored registers are taken and leave the tracker idle.
`timescale 1ns / 1ps
`include "top_k_play_count_tracker_defines.svh"

module top_k_play_count_tracker #(
    parameter int NUM_SONGS = 1024,
    parameter int K_MAX     = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // song_id [9:0], plays [39:10]
    input  logic [tkpc_pkg::DATA_W-1:0] i_s_tdata,
    // mode [0]
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // result_id [9:0], total_plays [39:10]
    output logic [tkpc_pkg::DATA_W-1:0] o_m_tdata,
    output logic                        o_m_tlast,
    // empty_answer [0]
    output logic                        o_m_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tkpc_pkg::TOP_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(NUM_SONGS);
    localparam int KW = $clog2(K_MAX + 1);
    localparam logic [AW-1:0] CLR_LAST  = AW'(NUM_SONGS - 1);
    localparam logic [KW-1:0] STEP_LAST = KW'(K_MAX - 1);
    localparam logic [7:0]    KMAX8     = 8'(K_MAX);

    tkpc_pkg::t_state r_state, n_state;

    logic [tkpc_pkg::ID_W-1:0]  r_id;
    logic [tkpc_pkg::TOT_W-1:0] r_plays;
    logic [AW-1:0]              r_clr_addr;
    logic [KW-1:0]              r_step;
    logic [KW-1:0]              r_k;
    logic [tkpc_pkg::TOP_W-1:0] r_top_count;

    logic                       r_out_valid;
    logic [tkpc_pkg::ID_W-1:0]  r_out_id;
    logic [tkpc_pkg::TOT_W-1:0] r_out_total;
    logic                       r_out_last;
    logic                       r_out_empty;

    logic                       w_accept;
    logic                       w_in_mode;
    logic [tkpc_pkg::ID_W-1:0]  w_in_id;
    logic [tkpc_pkg::TOT_W-1:0] w_in_plays;
    logic                       w_reg_ok;
    logic [7:0]                 w_tc8;
    logic [7:0]                 w_k8;
    logic [16:0]                w_id_ext;
    logic [AW-1:0]              w_id_addr;
    logic [tkpc_pkg::TOT_W:0]   w_sum;
    logic [tkpc_pkg::TOT_W-1:0] w_sat;
    logic [tkpc_pkg::TOT_W-1:0] w_rd_total;

    logic                       w_ram_we;
    logic [AW-1:0]              w_ram_waddr;
    logic [tkpc_pkg::TOT_W-1:0] w_ram_wdata;
    tkpc_pkg::t_rank_cmd        w_cmd;
    tkpc_pkg::t_rank_stat       w_stat;
    logic                       w_head_valid;
    logic                       w_emit;
    logic                       w_out_free;
    logic                       w_out_load;
    logic                       w_q_step;
    logic                       w_s_ready;

    assign w_in_id    = i_s_tdata[9:0];
    assign w_in_plays = i_s_tdata[39:10];
    assign w_in_mode  = i_s_tuser;
    assign w_accept   = i_s_tvalid && w_s_ready;
    assign w_reg_ok   = (w_in_plays != '0) && ({7'b0, w_in_id} < 17'(NUM_SONGS));

    // Clamp the configured count into the range 1 to K_MAX.
    always_comb begin
        w_tc8 = {3'b0, r_top_count};
        if (w_tc8 == 8'd0) begin
            w_k8 = 8'd1;
        end else if (w_tc8 > KMAX8) begin
            w_k8 = KMAX8;
        end else begin
            w_k8 = w_tc8;
        end
    end

    assign w_id_ext  = {7'b0, r_id};
    assign w_id_addr = w_id_ext[AW-1:0];

    // Both operands are below 2^30, so the carry bit flags saturation.
    assign w_sum = {1'b0, w_rd_total} + {1'b0, r_plays};
    assign w_sat = w_sum[tkpc_pkg::TOT_W] ? tkpc_pkg::TOTAL_MAX : w_sum[tkpc_pkg::TOT_W-1:0];

    assign w_head_valid = (w_stat.head.total != '0);
    assign w_emit       = (r_step < r_k) && (w_head_valid || (r_step == '0));
    assign w_out_free   = !r_out_valid || i_m_tready;

    tkpc_totals_ram #(
        .DEPTH (NUM_SONGS),
        .AW    (AW)
    ) u_totals (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_id_addr),
        .o_rdata (w_rd_total)
    );

    tkpc_rank_list #(
        .K_MAX (K_MAX)
    ) u_rank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tkpc_pkg::ST_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = tkpc_pkg::ST_IDLE;
                end
            end
            tkpc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (w_in_mode == tkpc_pkg::MODE_QUERY) begin
                        n_state = tkpc_pkg::ST_QUERY;
                    end else if (w_reg_ok) begin
                        n_state = tkpc_pkg::ST_READ;
                    end
                end
            end
            tkpc_pkg::ST_READ: begin
                n_state = tkpc_pkg::ST_ADD;
            end
            tkpc_pkg::ST_ADD: begin
                n_state = tkpc_pkg::ST_INSERT;
            end
            tkpc_pkg::ST_INSERT: begin
                if (r_step == STEP_LAST) begin
                    n_state = tkpc_pkg::ST_IDLE;
                end
            end
            tkpc_pkg::ST_QUERY: begin
                if (w_q_step && (r_step == STEP_LAST)) begin
                    n_state = tkpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tkpc_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        w_s_ready    = 1'b0;
        w_ram_we     = 1'b0;
        w_ram_waddr  = w_id_addr;
        w_ram_wdata  = w_sat;
        w_out_load   = 1'b0;
        w_q_step     = 1'b0;
        w_cmd.load   = 1'b0;
        w_cmd.step   = 1'b0;
        w_cmd.insert = 1'b0;
        w_cmd.entry  = '{id: r_id, total: w_sat};
        case (r_state)
            tkpc_pkg::ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            tkpc_pkg::ST_IDLE: begin
                w_s_ready = 1'b1;
            end
            tkpc_pkg::ST_READ: begin
            end
            tkpc_pkg::ST_ADD: begin
                w_ram_we   = 1'b1;
                w_cmd.load = 1'b1;
            end
            tkpc_pkg::ST_INSERT: begin
                w_cmd.step   = 1'b1;
                w_cmd.insert = 1'b1;
            end
            tkpc_pkg::ST_QUERY: begin
                w_out_load = w_emit && w_out_free;
                w_q_step   = !w_emit || w_out_free;
                w_cmd.step = w_q_step;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tkpc_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_step      <= '0;
            r_k         <= KW'(1);
            r_top_count <= tkpc_pkg::TOP_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tkpc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_valid) begin
                r_top_count <= i_cfg_data;
            end
            if (w_accept) begin
                r_step <= '0;
                r_k    <= w_k8[KW-1:0];
            end else if ((r_state == tkpc_pkg::ST_INSERT) || w_q_step) begin
                r_step <= r_step + KW'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_id    <= w_in_id;
            r_plays <= w_in_plays;
        end
        if (w_out_load) begin
            if (w_head_valid) begin
                r_out_id    <= w_stat.head.id;
                r_out_total <= w_stat.head.total;
                r_out_last  <= (r_step == (r_k - KW'(1))) || !w_stat.next_valid;
                r_out_empty <= 1'b0;
            end else begin
                r_out_id    <= '0;
                r_out_total <= '0;
                r_out_last  <= 1'b0;
                r_out_empty <= 1'b1;
            end
        end
    end

    assign o_s_tready  = w_s_ready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out_total, r_out_id};
    assign o_m_tlast   = r_out_last;
    assign o_m_tuser   = r_out_empty;

    `TKPC_ASSERT_NEXT(a_add_starts_merge, i_clk, i_rst_n, r_state == tkpc_pkg::ST_ADD, (r_state == tkpc_pkg::ST_INSERT) && (r_step == '0), "merge did not start after the add")
    `TKPC_ASSERT_NEXT(a_stall_holds_step, i_clk, i_rst_n, (r_state == tkpc_pkg::ST_QUERY) && w_emit && r_out_valid && !i_m_tready, $stable(r_step), "query rotated past a stalled result")
    `TKPC_ASSERT_NOW(a_clear_writes, i_clk, i_rst_n, r_state == tkpc_pkg::ST_CLEAR, w_ram_we && (w_ram_wdata == '0) && !w_s_ready, "clearing pass not writing zeros")
    `TKPC_ASSERT_NOW(a_empty_shape, i_clk, i_rst_n, r_out_valid && r_out_empty, !r_out_last && (r_out_total == '0) && (r_out_id == '0), "empty answer carries data")

endmodule

// ----- tb/sv/tb_top_k_play_count_tracker.sv -----
// Self-checking testbench for the top-K play count tracker.
// Depends on tkpc_pkg and top_k_play_count_tracker; it predicts every query answer
// with its own copy of the totals table and the ranked list.
`timescale 1ns / 1ps

module tb_top_k_play_count_tracker;

    import tkpc_pkg::*;

    localparam int NUM_SONGS    = 1024;
    localparam int K_MAX        = 16;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [ID_W-1:0]  result_id;
        logic [TOT_W-1:0] total_plays;
        logic             last;
        logic             empty_answer;
    } t_answer;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata;
    logic              i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [DATA_W-1:0] o_m_tdata;
    logic              o_m_tlast;
    logic              o_m_tuser;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [TOP_W-1:0]  i_cfg_data;

    // Predictor state: per-id totals, the ranked board and the query size.
    logic [TOT_W-1:0]  song_total [NUM_SONGS];
    logic [ID_W-1:0]   board_id [K_MAX];
    logic [TOT_W-1:0]  board_total [K_MAX];
    logic [TOP_W-1:0]  top_count;

    t_answer           answer_q[$];
    t_answer           want_answer;
    t_answer           got_answer;
    int                mismatches;
    int                quiet_cycles;
    int                tx_idle_pct;
    int                rx_stall_pct;

    top_k_play_count_tracker #(
        .NUM_SONGS(NUM_SONGS),
        .K_MAX    (K_MAX)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // True when entry (ta, ia) ranks above entry (tb, ib).
    function automatic bit outranks(logic [TOT_W-1:0] ta, logic [ID_W-1:0] ia,
                                    logic [TOT_W-1:0] tb, logic [ID_W-1:0] ib);
        return (ta > tb) || (ta == tb && ia > ib);
    endfunction

    function automatic void board_update(logic [ID_W-1:0] id, logic [TOT_W-1:0] total);
        int n;
        int pos;
        int q;
        n   = 0;
        pos = -1;
        while (n < K_MAX && board_total[n] != '0) begin
            if (board_id[n] == id)
                pos = n;
            n++;
        end
        // A listed id leaves its slot first and is then placed again.
        if (pos >= 0) begin
            for (int i = pos; i + 1 < n; i++) begin
                board_id[i]    = board_id[i + 1];
                board_total[i] = board_total[i + 1];
            end
            n--;
            board_id[n]    = '0;
            board_total[n] = '0;
        end
        if (n >= K_MAX) begin
            if (!outranks(total, id, board_total[K_MAX - 1], board_id[K_MAX - 1]))
                return;
            n = K_MAX - 1;
        end
        q = 0;
        while (q < n && !outranks(total, id, board_total[q], board_id[q]))
            q++;
        for (int i = n; i > q; i--) begin
            board_id[i]    = board_id[i - 1];
            board_total[i] = board_total[i - 1];
        end
        board_id[q]    = id;
        board_total[q] = total;
    endfunction

    function automatic void predict_item(logic mode, logic [ID_W-1:0] id,
                                         logic [TOT_W-1:0] plays);
        logic [TOT_W:0] sum;
        int             k;
        int             n;
        t_answer        ans;
        if (mode == MODE_REGISTER) begin
            if (plays == '0)
                return;
            sum = {1'b0, song_total[id]} + {1'b0, plays};
            if (sum > {1'b0, TOTAL_MAX})
                sum = {1'b0, TOTAL_MAX};
            song_total[id] = sum[TOT_W-1:0];
            board_update(id, sum[TOT_W-1:0]);
        end else begin
            k = top_count;
            if (k == 0)
                k = 1;
            if (k > K_MAX)
                k = K_MAX;
            n = 0;
            while (n < k && board_total[n] != '0)
                n++;
            if (n == 0) begin
                ans              = '0;
                ans.empty_answer = 1'b1;
                answer_q = {answer_q, ans};
            end else begin
                for (int i = 0; i < n; i++) begin
                    ans.result_id    = board_id[i];
                    ans.total_plays  = board_total[i];
                    ans.last         = (i == n - 1);
                    ans.empty_answer = 1'b0;
                    answer_q = {answer_q, ans};
                end
            end
        end
    endfunction

    function automatic void flag_mismatch(string what, t_answer want, t_answer got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected id=%0d total=%0d last=%0b empty=%0b, got id=%0d total=%0d last=%0b empty=%0b",
                     $time, what, want.result_id, want.total_plays, want.last,
                     want.empty_answer, got.result_id, got.total_plays, got.last,
                     got.empty_answer);
    endfunction

    // Output monitor: every result transaction is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_answer.result_id    = o_m_tdata[ID_W-1:0];
            got_answer.total_plays  = o_m_tdata[ID_W +: TOT_W];
            got_answer.last         = o_m_tlast;
            got_answer.empty_answer = o_m_tuser;
            if (answer_q.size() == 0) begin
                flag_mismatch("unexpected result", '0, got_answer);
            end else begin
                want_answer = answer_q.pop_front();
                if (got_answer !== want_answer)
                    flag_mismatch("result mismatch", want_answer, got_answer);
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // The run ends if no transaction of any kind completes for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_top_k_play_count_tracker NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(input logic mode, input logic [ID_W-1:0] id,
                             input logic [TOT_W-1:0] plays);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {plays, id};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        predict_item(mode, id, plays);
    endtask

    // Registers never produce a result, so a fixed pause covers one still in flight.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_top_count(input logic [TOP_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        top_count = value;
    endtask

    task automatic test_empty_query();
        send_item(MODE_QUERY, '0, '0);
    endtask

    task automatic test_field_edges();
        send_item(MODE_REGISTER, '0, TOT_W'(1));
        send_item(MODE_REGISTER, {ID_W{1'b1}}, TOTAL_MAX);
        // The second add on a full total must stick at the maximum.
        send_item(MODE_REGISTER, {ID_W{1'b1}}, TOT_W'(5));
        send_item(MODE_REGISTER, ID_W'(682), '0);
        write_top_count(TOP_W'(K_MAX));
        send_item(MODE_QUERY, {ID_W{1'b1}}, TOTAL_MAX);
    endtask

    task automatic test_rank_order();
        // Equal totals put the higher id first; a growing total moves an id up.
        send_item(MODE_REGISTER, ID_W'(512), TOT_W'(1));
        send_item(MODE_REGISTER, '0, TOT_W'(1));
        send_item(MODE_REGISTER, ID_W'(341), TOT_W'(2));
        send_item(MODE_QUERY, '0, '0);
    endtask

    task automatic test_count_limits();
        write_top_count('0);
        send_item(MODE_QUERY, '0, '0);
        write_top_count({TOP_W{1'b1}});
        send_item(MODE_QUERY, '0, '0);
        write_top_count(TOP_W'(2));
        send_item(MODE_QUERY, '0, '0);
    endtask

    task automatic test_random_phase(input int items, input int tx_pct, input int rx_pct,
                                     input logic [TOP_W-1:0] count);
        logic             mode;
        logic [ID_W-1:0]  id;
        logic [TOT_W-1:0] plays;
        int               pick;
        write_top_count(count);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < items; i++) begin
            mode = ($urandom_range(0, 99) < 20) ? MODE_QUERY : MODE_REGISTER;
            // A small pool of ids keeps entries competing for the board.
            pick = $urandom_range(0, 99);
            if (pick < 75)
                id = ID_W'($urandom_range(0, 47) * 21);
            else
                id = ID_W'($urandom_range(0, NUM_SONGS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                plays = TOT_W'($urandom_range(1, 20));
            else if (pick < 85)
                plays = TOT_W'($urandom_range(1, 5000));
            else if (pick < 95)
                plays = TOT_W'($urandom_range(1, 1 << 20));
            else if (pick < 98)
                plays = TOT_W'($urandom);
            else
                plays = '0;
            send_item(mode, id, plays);
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_s_tvalid   <= 1'b0;
        i_s_tdata    <= '0;
        i_s_tuser    <= 1'b0;
        i_m_tready   <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        mismatches   = 0;
        quiet_cycles = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        top_count    = TOP_W'(1);
        for (int i = 0; i < NUM_SONGS; i++)
            song_total[i] = '0;
        for (int i = 0; i < K_MAX; i++) begin
            board_id[i]    = '0;
            board_total[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_query();
        test_field_edges();
        test_rank_order();
        test_count_limits();
        test_random_phase(120, 0, 0, TOP_W'(K_MAX));
        test_random_phase(120, 47, 0, '0);
        test_random_phase(120, 0, 47, {TOP_W{1'b1}});
        test_random_phase(120, 11, 11, TOP_W'(9));

        wait_drained();
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("tb_top_k_play_count_tracker OK");
        end else begin
            $display("tb_top_k_play_count_tracker NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/tkpc_pkg.sv
hdl/tkpc_totals_ram.sv
hdl/tkpc_rank_list.sv
hdl/top_k_play_count_tracker.sv
tb/sv/tb_top_k_play_count_tracker.sv
